@@ sv/xesc_pkg.sv @@
// Package for the XML-escaping UTF-8 encoder: character classes, byte buffer
// type and the byte builder used by the pipeline.
// No dependencies.
package xesc_pkg;

    // Maximum bytes one code point can expand to
    localparam int unsigned MAX_BYTES = 6;

    // Character class decided in the first stage
    typedef enum logic [3:0] {
        CLS_DROP,
        CLS_EOS,
        CLS_LT,
        CLS_GT,
        CLS_AMP,
        CLS_APOS,
        CLS_QUOT,
        CLS_BR,
        CLS_ASCII,
        CLS_TWO,
        CLS_THREE
    } char_class_t;

    // Code points with special treatment
    localparam logic [20:0] CP_NEWLINE = 21'h00000A;
    localparam logic [20:0] CP_QUOT    = 21'h000022;
    localparam logic [20:0] CP_AMP     = 21'h000026;
    localparam logic [20:0] CP_APOS    = 21'h000027;
    localparam logic [20:0] CP_LT      = 21'h00003C;
    localparam logic [20:0] CP_GT      = 21'h00003E;
    localparam logic [20:0] CP_CTRL_LIMIT = 21'h000020;
    localparam logic [20:0] CP_ONE_LIMIT  = 21'h000080;
    localparam logic [20:0] CP_TWO_LIMIT  = 21'h000800;
    localparam logic [20:0] CP_BMP_MAX    = 21'h00FFFF;

    // UTF-8 lead and continuation marks
    localparam logic [7:0] LEAD_TWO   = 8'hC0;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] CONT_MARK  = 8'h80;

    // ASCII bytes for the entity text
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_O     = 8'h6F;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_Q     = 8'h71;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Byte buffer: entry 0 goes out first
    typedef logic [MAX_BYTES-1:0][7:0] byte_buf_t;
    typedef logic [2:0] byte_idx_t;

    typedef struct packed {
        byte_buf_t bytes;
        byte_idx_t last_idx;
    } byte_run_t;

    // Classify one input item
    function automatic char_class_t classify(
        input logic [20:0] cp,
        input logic        eos,
        input logic        allow_nl
    );
        char_class_t cls;
        if (eos)                     cls = CLS_EOS;
        else if (cp == CP_LT)        cls = CLS_LT;
        else if (cp == CP_GT)        cls = CLS_GT;
        else if (cp == CP_AMP)       cls = CLS_AMP;
        else if (cp == CP_APOS)      cls = CLS_APOS;
        else if (cp == CP_QUOT)      cls = CLS_QUOT;
        else if (cp == CP_NEWLINE)   cls = allow_nl ? CLS_BR : CLS_DROP;
        else if (cp < CP_CTRL_LIMIT) cls = CLS_DROP;
        else if (cp < CP_ONE_LIMIT)  cls = CLS_ASCII;
        else if (cp < CP_TWO_LIMIT)  cls = CLS_TWO;
        else if (cp <= CP_BMP_MAX)   cls = CLS_THREE;
        else                         cls = CLS_DROP;
        return cls;
    endfunction

    // Expand a class and the low 16 code point bits into the byte run
    function automatic byte_run_t build_run(
        input char_class_t cls,
        input logic [15:0] cp
    );
        byte_run_t run;
        run.bytes    = '0;
        run.last_idx = 3'd0;
        case (cls)
            CLS_EOS:
            begin
                run.bytes[0] = CH_NUL;
                run.last_idx = 3'd0;
            end
            CLS_LT:
            begin
                run.bytes[0] = CH_AMP;
                run.bytes[1] = CH_L;
                run.bytes[2] = CH_T;
                run.bytes[3] = CH_SEMI;
                run.last_idx = 3'd3;
            end
            CLS_GT:
            begin
                run.bytes[0] = CH_AMP;
                run.bytes[1] = CH_G;
                run.bytes[2] = CH_T;
                run.bytes[3] = CH_SEMI;
                run.last_idx = 3'd3;
            end
            CLS_AMP:
            begin
                run.bytes[0] = CH_AMP;
                run.bytes[1] = CH_A;
                run.bytes[2] = CH_M;
                run.bytes[3] = CH_P;
                run.bytes[4] = CH_SEMI;
                run.last_idx = 3'd4;
            end
            CLS_APOS:
            begin
                run.bytes[0] = CH_AMP;
                run.bytes[1] = CH_A;
                run.bytes[2] = CH_P;
                run.bytes[3] = CH_O;
                run.bytes[4] = CH_S;
                run.bytes[5] = CH_SEMI;
                run.last_idx = 3'd5;
            end
            CLS_QUOT:
            begin
                run.bytes[0] = CH_AMP;
                run.bytes[1] = CH_Q;
                run.bytes[2] = CH_U;
                run.bytes[3] = CH_O;
                run.bytes[4] = CH_T;
                run.bytes[5] = CH_SEMI;
                run.last_idx = 3'd5;
            end
            CLS_BR:
            begin
                run.bytes[0] = CH_LT;
                run.bytes[1] = CH_B;
                run.bytes[2] = CH_R;
                run.bytes[3] = CH_SLASH;
                run.bytes[4] = CH_GT;
                run.last_idx = 3'd4;
            end
            CLS_ASCII:
            begin
                run.bytes[0] = {1'b0, cp[6:0]};
                run.last_idx = 3'd0;
            end
            CLS_TWO:
            begin
                run.bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
                run.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
                run.last_idx = 3'd1;
            end
            CLS_THREE:
            begin
                run.bytes[0] = LEAD_THREE | {4'b0000, cp[15:12]};
                run.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
                run.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
                run.last_idx = 3'd2;
            end
            default:
            begin
                run.bytes    = '0;
                run.last_idx = 3'd0;
            end
        endcase
        return run;
    endfunction

endpackage

@@ sv/xml_escape_utf8_encoder.sv @@
// Path: each item passes the classify, build and serialise registers in that
// order to the first output byte, then one byte per cycle while out_stall is low.
// Throughput: one code point per cycle when each yields one byte and out_stall
// is low; an item producing n bytes (up to 6) holds the output port until its
// last byte is taken. Dropped characters are taken at the input and occupy no stage.
// Reset: all valid bits clear, the newline-allow register returns to 1.
// Top level of the XML-escaping UTF-8 encoder; three-stage pipeline.
// Depends on xesc_pkg.
module xml_escape_utf8_encoder
    import xesc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        allow_newlines,
    // code point input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [20:0] code_point,
    input  logic        end_of_string,
    // byte output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last_of_run
);

    logic        allow_nl_reg;

    // stage A: class and code point bits
    logic        a_valid_reg, a_valid_next;
    char_class_t a_cls_reg;
    logic [15:0] a_cp_reg;

    // stage B: built byte run
    logic        b_valid_reg, b_valid_next;
    byte_run_t   b_run_reg;

    // stage C: serialiser / output register
    logic        ser_valid_reg, ser_valid_next;
    byte_buf_t   ser_bytes_reg;
    byte_idx_t   ser_last_reg;
    byte_idx_t   ser_idx_reg, ser_idx_next;

    logic        a_ready, b_ready, ser_free, ser_at_last;
    char_class_t in_cls;

    // Configuration register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            allow_nl_reg <= 1'b1;
        else if (cfg_valid && cfg_ready)
            allow_nl_reg <= allow_newlines;
    end

    // Handshake chain
    assign ser_at_last = (ser_idx_reg == ser_last_reg);
    assign ser_free    = !ser_valid_reg || (!out_stall && ser_at_last);
    assign b_ready     = !b_valid_reg || ser_free;
    assign a_ready     = !a_valid_reg || b_ready;
    assign in_stall    = !a_ready;

    // Stage A: classify; dropped characters are taken but not passed on
    assign in_cls = classify(code_point, end_of_string, allow_nl_reg);

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (a_ready)
            a_valid_next = in_valid && (in_cls != CLS_DROP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= a_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_cls_reg <= in_cls;
            a_cp_reg  <= code_point[15:0];
        end
    end

    // Stage B: expand to byte run
    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (b_ready)
            b_valid_next = a_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= b_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
            b_run_reg <= build_run(a_cls_reg, a_cp_reg);
    end

    // Stage C: step through the run one byte per output transaction
    always_comb
    begin
        ser_valid_next = ser_valid_reg;
        ser_idx_next   = ser_idx_reg;
        if (ser_free)
        begin
            ser_valid_next = b_valid_reg;
            ser_idx_next   = 3'd0;
        end
        else if (!out_stall)
        begin
            ser_idx_next = ser_idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            ser_idx_reg   <= 3'd0;
        end
        else
        begin
            ser_valid_reg <= ser_valid_next;
            ser_idx_reg   <= ser_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ser_free && b_valid_reg)
        begin
            ser_bytes_reg <= b_run_reg.bytes;
            ser_last_reg  <= b_run_reg.last_idx;
        end
    end

    // Output port
    assign out_valid   = ser_valid_reg;
    assign out_byte    = ser_bytes_reg[ser_idx_reg];
    assign last_of_run = ser_at_last;

    // Byte index never runs past the end of its run
    assert property (@(posedge clk) disable iff (!rst_n)
        ser_valid_reg |-> (ser_idx_reg <= ser_last_reg))
        else $error("serialiser index beyond last byte");

    // A run never exceeds the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        ser_valid_reg |-> (ser_last_reg <= 3'd5))
        else $error("byte run longer than buffer");

    // A byte taken that is not the last is followed by the next byte of the run
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_of_run) |=>
            (out_valid && ser_idx_reg == $past(ser_idx_reg) + 3'd1))
        else $error("run broken before its last byte");

    // After the last byte, any new run starts at its first byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_of_run) |=>
            (!out_valid || ser_idx_reg == 3'd0))
        else $error("new run not started at first byte");

    // Input is held off only while stages A, B and the serialiser are all occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (a_valid_reg && b_valid_reg && ser_valid_reg))
        else $error("input stalled with room in the pipeline");

endmodule
